@@ design/u8d_pkg.sv @@
package u8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned CONT_W = 6;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_TRUNC   = 2'd2;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  typedef struct packed {
    logic [1:0]      bytes_left;
    logic [CP_W-1:0] partial_value;
    logic [2:0]      seq_total;
  } seq_state_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [2:0]      seq_bytes;
    status_t         status;
    logic [7:0]      bad_byte;
    logic            final_result;
  } result_t;

endpackage

@@ design/u8d_if.sv @@
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, data_byte, end_of_text, input ready);
  modport sink (input valid, data_byte, end_of_text, output ready);
  modport monitor (input valid, ready, data_byte, end_of_text);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  seq_bytes;
  logic [1:0]  status;
  logic [7:0]  bad_byte;
  logic        final_result;

  modport source (output valid, code_point, seq_bytes, status, bad_byte, final_result,
                  input ready);
  modport sink (input valid, code_point, seq_bytes, status, bad_byte, final_result,
                output ready);
  modport monitor (input valid, ready, code_point, seq_bytes, status, bad_byte,
                   final_result);
endinterface

@@ design/utf8_stream_decoder.sv @@
// An accepted byte is registered in the input stage, then its result beat in the output register.
// Throughput: one byte per cycle unless the output stalls; a new byte is
// taken while a result waits, set by the state register updated once per byte.
// Reset (rst, synchronous): clears input and output valid and the sequence
// state, so the next byte is treated as a lead byte.
module utf8_stream_decoder (
  input logic       clk,
  input logic       rst,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch
);
  import u8d_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_fin;

  seq_state_t st;
  seq_state_t st_next;
  logic       res_valid;
  result_t    res;

  logic       out_valid;
  result_t    out_res;
  logic       advance;

  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || !out_valid || out_ch.ready;

  u8d_step step (
    .st          (st),
    .data_byte   (in_byte),
    .end_of_text (in_fin),
    .st_next     (st_next),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte <= in_ch.data_byte;
      in_fin  <= in_ch.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.code_point   = out_res.code_point;
  assign out_ch.seq_bytes    = out_res.seq_bytes;
  assign out_ch.status       = out_res.status;
  assign out_ch.bad_byte     = out_res.bad_byte;
  assign out_ch.final_result = out_res.final_result;

endmodule

@@ design/u8d_step.sv @@
module u8d_step (
  input  u8d_pkg::seq_state_t st,
  input  logic [7:0]          data_byte,
  input  logic                end_of_text,
  output u8d_pkg::seq_state_t st_next,
  output logic                res_valid,
  output u8d_pkg::result_t    res
);
  import u8d_pkg::*;

  logic [CP_W-1:0] shifted;
  logic [1:0]      left_dec;
  logic [2:0]      lead_len;
  logic [CP_W-1:0] lead_bits;
  logic            lead_multi;

  assign shifted  = {st.partial_value[CP_W-CONT_W-1:0], data_byte[CONT_W-1:0]};
  assign left_dec = st.bytes_left - 2'd1;

  always_comb begin
    lead_len   = LEN_NONE;
    lead_bits  = '0;
    lead_multi = 1'b0;
    priority if (data_byte[7] == 1'b0) begin
      lead_len = LEN_ONE;
    end else if (data_byte[7:5] == 3'b110) begin
      lead_len   = LEN_TWO;
      lead_bits  = {16'd0, data_byte[4:0]};
      lead_multi = 1'b1;
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_len   = LEN_THREE;
      lead_bits  = {17'd0, data_byte[3:0]};
      lead_multi = 1'b1;
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_len   = LEN_FOUR;
      lead_bits  = {18'd0, data_byte[2:0]};
      lead_multi = 1'b1;
    end else begin
      lead_len = LEN_NONE;
    end
  end

  always_comb begin
    st_next   = st;
    res_valid = 1'b0;
    res       = '{code_point: '0, seq_bytes: LEN_NONE, status: ST_OK, bad_byte: '0,
                  final_result: end_of_text};
    if (st.bytes_left == 2'd0) begin
      if (lead_len == LEN_ONE) begin
        res_valid      = 1'b1;
        res.code_point = {13'd0, data_byte};
        res.seq_bytes  = LEN_ONE;
      end else if (!lead_multi) begin
        res_valid    = 1'b1;
        res.status   = ST_INVALID;
        res.bad_byte = data_byte;
      end else if (end_of_text) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNC;
        st_next    = '0;
      end else begin
        st_next.partial_value = lead_bits;
        st_next.seq_total     = lead_len;
        st_next.bytes_left    = lead_len[1:0] - 2'd1;
      end
    end else begin
      if (left_dec == 2'd0) begin
        res_valid      = 1'b1;
        res.code_point = shifted;
        res.seq_bytes  = st.seq_total;
        st_next        = '0;
      end else if (end_of_text) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNC;
        st_next    = '0;
      end else begin
        st_next.partial_value = shifted;
        st_next.bytes_left    = left_dec;
      end
    end
  end

endmodule

@@ design/u8d_checker.sv @@
module u8d_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [u8d_pkg::CP_W-1:0] code_point,
  input logic [2:0]             seq_bytes,
  input u8d_pkg::status_t       status,
  input logic [7:0]             bad_byte,
  input logic                   final_result
);
  import u8d_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point)
      && $stable(status) && $stable(seq_bytes))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> code_point == '0
      && seq_bytes == LEN_NONE)
    else $error("error beat carries a code point");

  a_trunc_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TRUNC |-> final_result && bad_byte == '0)
    else $error("truncated beat not final");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> seq_bytes != LEN_NONE
      && seq_bytes <= LEN_FOUR)
    else $error("bad sequence length");

  a_bad_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_INVALID |-> bad_byte[7:6] == 2'b10
      || bad_byte[7:3] == 5'b11111)
    else $error("valid lead reported as invalid");

endmodule

bind utf8_stream_decoder u8d_checker chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .code_point   (out_ch.code_point),
  .seq_bytes    (out_ch.seq_bytes),
  .status       (out_ch.status),
  .bad_byte     (out_ch.bad_byte),
  .final_result (out_ch.final_result)
);

@@ test/tb_utf8_stream_decoder.sv @@
module tb_utf8_stream_decoder;
  import u8d_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_LEN       = 120;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } byte_beat_t;

  logic clk = 1'b0;
  logic rst;

  u8d_in_if  in_ch ();
  u8d_out_if out_ch ();

  utf8_stream_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  byte_beat_t pending_bytes[$];
  result_t    expected_chars[$];

  // decoder state mirror
  logic [1:0]      cont_left;
  logic [CP_W-1:0] acc_cp;
  logic [2:0]      seq_len;

  int src_idle_pct;
  int snk_idle_pct;
  int stall_asked;
  int stall_taken;
  int stall_left;
  int quiet_cycles;
  int bytes_queued;
  int bytes_sent;
  int results_seen;
  int invalid_seen;
  int trunc_seen;
  int mismatches;
  logic in_beat;

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    result_t         r;
    logic [2:0]      n;
    logic [CP_W-1:0] bits;
    r = '0;
    r.status = ST_OK;
    r.final_result = eot;
    n = LEN_NONE;
    bits = '0;
    if (cont_left == 2'd0) begin
      casez (b)
        8'b0???????: begin
          r.code_point = CP_W'(b);
          r.seq_bytes = LEN_ONE;
        end
        8'b110?????: begin
          n = LEN_TWO;
          bits = CP_W'(b[4:0]);
        end
        8'b1110????: begin
          n = LEN_THREE;
          bits = CP_W'(b[3:0]);
        end
        8'b11110???: begin
          n = LEN_FOUR;
          bits = CP_W'(b[2:0]);
        end
        default: begin
          r.status = ST_INVALID;
          r.bad_byte = b;
        end
      endcase
      if (n == LEN_NONE) begin
        expected_chars.push_back(r);
      end else if (eot) begin
        r.status = ST_TRUNC;
        expected_chars.push_back(r);
      end else begin
        acc_cp = bits;
        seq_len = n;
        cont_left = 2'(n - 3'd1);
      end
    end else begin
      acc_cp = {acc_cp[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        r.code_point = acc_cp;
        r.seq_bytes = seq_len;
        expected_chars.push_back(r);
      end else if (eot) begin
        r.status = ST_TRUNC;
        expected_chars.push_back(r);
      end
      if (cont_left == 2'd0 || eot) begin
        cont_left = 2'd0;
        acc_cp = '0;
        seq_len = LEN_NONE;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
               results_seen, what, got, want);
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (out_ch.status == ST_INVALID) invalid_seen++;
    if (out_ch.status == ST_TRUNC) trunc_seen++;
    if (expected_chars.size() == 0) begin
      report_mismatch("unexpected beat, code_point", 32'(out_ch.code_point), 0);
    end else begin
      want = expected_chars.pop_front();
      if (out_ch.code_point !== want.code_point)
        report_mismatch("code_point", 32'(out_ch.code_point), 32'(want.code_point));
      if (out_ch.seq_bytes !== want.seq_bytes)
        report_mismatch("seq_bytes", 32'(out_ch.seq_bytes), 32'(want.seq_bytes));
      if (out_ch.status !== want.status)
        report_mismatch("status", 32'(out_ch.status), 32'(want.status));
      if (out_ch.bad_byte !== want.bad_byte)
        report_mismatch("bad_byte", 32'(out_ch.bad_byte), 32'(want.bad_byte));
      if (out_ch.final_result !== want.final_result)
        report_mismatch("final_result", 32'(out_ch.final_result),
                        32'(want.final_result));
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eot);
    byte_beat_t item;
    item.data = b;
    item.eot = eot;
    pending_bytes.push_back(item);
    bytes_queued++;
  endtask

  task automatic queue_char();
    logic [2:0]      len;
    logic [CP_W-1:0] cp;
    logic            eot;
    len = 3'($urandom_range(4, 1));
    cp = CP_W'($urandom);
    eot = ($urandom_range(19) == 0);
    case (len)
      LEN_ONE: queue_byte({1'b0, cp[6:0]}, eot);
      LEN_TWO: begin
        queue_byte({3'b110, cp[10:6]}, 1'b0);
        queue_byte({2'b10, cp[5:0]}, eot);
      end
      LEN_THREE: begin
        queue_byte({4'b1110, cp[15:12]}, 1'b0);
        queue_byte({2'b10, cp[11:6]}, 1'b0);
        queue_byte({2'b10, cp[5:0]}, eot);
      end
      default: begin
        queue_byte({5'b11110, cp[20:18]}, 1'b0);
        queue_byte({2'b10, cp[17:12]}, 1'b0);
        queue_byte({2'b10, cp[11:6]}, 1'b0);
        queue_byte({2'b10, cp[5:0]}, eot);
      end
    endcase
  endtask

  task automatic queue_noise();
    logic [7:0] b;
    int         k;
    int         i;
    b = 8'($urandom);
    case ($urandom_range(3))
      0: queue_byte(b, $urandom_range(7) == 0);
      1: begin
        // invalid lead
        if (b[0]) b[7:6] = 2'b10;
        else b[7:3] = 5'b11111;
        queue_byte(b, $urandom_range(7) == 0);
      end
      2: begin
        // continuation bytes with arbitrary top bits
        k = $urandom_range(3, 1);
        if (k == 1) queue_byte({3'b110, b[4:0]}, 1'b0);
        else if (k == 2) queue_byte({4'b1110, b[3:0]}, 1'b0);
        else queue_byte({5'b11110, b[2:0]}, 1'b0);
        for (i = 0; i < k; i++) queue_byte(8'($urandom), 1'b0);
      end
      default: begin
        // stream ends inside a sequence
        k = $urandom_range(3, 1);
        if (k == 1) queue_byte({3'b110, b[4:0]}, 1'b1);
        else if (k == 2) queue_byte({4'b1110, b[3:0]}, $urandom_range(1) == 0);
        else queue_byte({5'b11110, b[2:0]}, $urandom_range(2) == 0);
        if (!pending_bytes[$].eot) begin
          k = $urandom_range(k - 1, 1);
          for (i = 0; i < k; i++) queue_byte({2'b10, 6'($urandom)}, i == k - 1);
        end
      end
    endcase
  endtask

  task automatic queue_random(input int nbytes);
    int target;
    target = bytes_queued + nbytes;
    while (bytes_queued < target) begin
      if ($urandom_range(9) < 8) queue_char();
      else queue_noise();
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || expected_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (!in_ch.valid || in_beat) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= pending_bytes[0].data;
        in_ch.end_of_text <= pending_bytes[0].eot;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with long hold-offs on request
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_taken != stall_asked) begin
      out_ch.ready <= 1'b0;
      stall_left <= HOLD_LEN;
      stall_taken <= stall_taken + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    in_beat <= !rst && in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.data_byte, in_ch.end_of_text);
        pending_bytes.delete(0);
        bytes_sent++;
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    in_beat = 1'b0;
    cont_left = 2'd0;
    acc_cp = '0;
    seq_len = LEN_NONE;
    src_idle_pct = 25;
    snk_idle_pct = 69;
    stall_asked = 0;
    stall_taken = 0;
    stall_left = 0;
    quiet_cycles = 0;
    bytes_queued = 0;
    bytes_sent = 0;
    results_seen = 0;
    invalid_seen = 0;
    trunc_seen = 0;
    mismatches = 0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    @(posedge clk);

    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hC2, 1'b0);
    queue_byte(8'hA9, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hAC, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hF7, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hF8, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b1);
    queue_byte(8'hF0, 1'b1);
    queue_byte(8'h41, 1'b1);
    queue_byte(8'hBF, 1'b1);
    drain();

    queue_random(170);
    drain();

    src_idle_pct = 69;
    snk_idle_pct = 25;
    queue_random(170);
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    stall_asked = stall_asked + 1;
    queue_random(160);
    drain();

    $display("Sent %0d bytes, checked %0d results (%0d invalid lead, %0d truncated),",
             bytes_sent, results_seen, invalid_seen, trunc_seen);
    $display("under three idle mixes and a %0d-cycle output hold-off.", HOLD_LEN);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/u8d_pkg.sv
design/u8d_if.sv
design/u8d_step.sv
design/utf8_stream_decoder.sv
design/u8d_checker.sv
test/tb_utf8_stream_decoder.sv
